// File: hdl/ricrc_pkg.sv
// ----------------------------------------------------------------------------
// ricrc_pkg
// shared types, constants and crc helpers for the invariant crc engine
// ----------------------------------------------------------------------------
package ricrc_pkg;

  localparam int unsigned PAYLOAD_LIMIT = 1024;

  localparam logic [31:0] CRC_POLY = 32'hedb88320;
  localparam logic [31:0] CRC_ALL  = 32'hffffffff;

  localparam int unsigned CNT_W  = 17;
  localparam int unsigned TLEN_W = 16;
  localparam int unsigned CMP_W  = 18;

  localparam logic [CNT_W-1:0] ETH_HDR    = CNT_W'(14);
  localparam logic [CMP_W-1:0] IP_HDR_MIN = CMP_W'(20);
  localparam logic [CMP_W-1:0] FRAME_MIN  = CMP_W'(38);
  localparam logic [CMP_W-1:0] TLEN_MIN   = CMP_W'(4);
  localparam logic [CMP_W-1:0] TLEN_MAX   = CMP_W'(44 + PAYLOAD_LIMIT);

  // fixed ip offsets; tos, ttl and checksum bytes are masked
  localparam logic [CNT_W-1:0] OFS_IHL     = CNT_W'(0);
  localparam logic [CNT_W-1:0] OFS_TOS     = CNT_W'(1);
  localparam logic [CNT_W-1:0] OFS_LEN_HI  = CNT_W'(2);
  localparam logic [CNT_W-1:0] OFS_LEN_LO  = CNT_W'(3);
  localparam logic [CNT_W-1:0] OFS_TTL     = CNT_W'(8);
  localparam logic [CNT_W-1:0] OFS_CSUM_HI = CNT_W'(10);
  localparam logic [CNT_W-1:0] OFS_CSUM_LO = CNT_W'(11);
  // offsets relative to the end of the ip header
  localparam logic [CNT_W-1:0] REL_UCSUM_HI = CNT_W'(6);
  localparam logic [CNT_W-1:0] REL_UCSUM_LO = CNT_W'(7);
  localparam logic [CNT_W-1:0] REL_QPN      = CNT_W'(12);

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SHORT     = 3'd1,
    ST_LEN_BAD   = 3'd2,
    ST_TOO_LONG  = 3'd3,
    ST_HDR_BAD   = 3'd4
  } status_t;

  typedef struct packed {
    logic [7:0] data;
    logic       incl;
    logic       last;
    status_t    status;
  } q_entry_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'h0);
    end
    return c;
  endfunction

  function automatic logic [31:0] crc_seed();
    logic [31:0] c;
    c = CRC_ALL;
    for (int k = 0; k < 8; k++) begin
      c = crc_byte(c, 8'hff);
    end
    return c;
  endfunction

  localparam logic [31:0] CRC_PRESET = crc_seed();

endpackage

// File: hdl/ricrc_front.sv
// ----------------------------------------------------------------------------
// ricrc_front
// tracks frame position and ip lengths, masks bytes, decides status on last
// ----------------------------------------------------------------------------
module ricrc_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic [7:0]          in_frame_byte,
  input  logic                in_last_byte,
  output logic                push,
  output ricrc_pkg::q_entry_t push_entry
);
  import ricrc_pkg::*;

  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [TLEN_W-1:0] tlen_r, tlen_nxt;
  logic [3:0]        hw_r, hw_nxt;

  logic [CNT_W-1:0]  ofs;
  logic [CNT_W-1:0]  ihl_old;
  logic [CMP_W-1:0]  ihl_new;
  logic [CNT_W-1:0]  cnt_sat;
  logic              in_hdr;
  logic              masked;
  status_t           status;

  always_comb begin
    push     = in_valid && !in_stall;
    in_hdr   = cnt_r >= ETH_HDR;
    ofs      = cnt_r - ETH_HDR;
    ihl_old  = CNT_W'({hw_r, 2'b00});
    cnt_sat  = (cnt_r != {CNT_W{1'b1}}) ? cnt_r + CNT_W'(1) : cnt_r;

    hw_nxt   = hw_r;
    tlen_nxt = tlen_r;
    if (in_hdr) begin
      if (ofs == OFS_IHL) hw_nxt = in_frame_byte[3:0];
      else if (ofs == OFS_LEN_HI) tlen_nxt = {in_frame_byte, tlen_r[7:0]};
      else if (ofs == OFS_LEN_LO) tlen_nxt = {tlen_r[15:8], in_frame_byte};
    end
    ihl_new = CMP_W'({hw_nxt, 2'b00});

    // invariant fields read as all ones
    masked = (ofs == OFS_TOS) || (ofs == OFS_TTL) || (ofs == OFS_CSUM_HI) ||
             (ofs == OFS_CSUM_LO) ||
             ((ofs != OFS_IHL) && ((ofs == ihl_old + REL_UCSUM_HI) ||
                                   (ofs == ihl_old + REL_UCSUM_LO) ||
                                   (ofs == ihl_old + REL_QPN)));

    push_entry.data = masked ? 8'hff : in_frame_byte;
    push_entry.incl = in_hdr && ((ofs < CNT_W'(4)) ||
                      (CMP_W'(ofs) + CMP_W'(4) < CMP_W'(tlen_nxt)));
    push_entry.last = in_last_byte;

    // error priority: short, inconsistent, too long, bad header
    if (CMP_W'(cnt_sat) < FRAME_MIN) status = ST_SHORT;
    else if ((CMP_W'(tlen_nxt) + CMP_W'(ETH_HDR) > CMP_W'(cnt_sat)) ||
             (CMP_W'(tlen_nxt) < TLEN_MIN)) status = ST_LEN_BAD;
    else if (CMP_W'(tlen_nxt) > TLEN_MAX) status = ST_TOO_LONG;
    else if ((ihl_new < IP_HDR_MIN) || (CMP_W'(tlen_nxt) < ihl_new + IP_HDR_MIN))
      status = ST_HDR_BAD;
    else status = ST_OK;
    push_entry.status = status;

    cnt_nxt = cnt_r;
    if (push) begin
      if (in_last_byte) begin
        cnt_nxt  = '0;
        tlen_nxt = '0;
        hw_nxt   = '0;
      end else begin
        cnt_nxt = cnt_sat;
      end
    end else begin
      tlen_nxt = tlen_r;
      hw_nxt   = hw_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      tlen_r <= '0;
      hw_r   <= '0;
    end else begin
      cnt_r  <= cnt_nxt;
      tlen_r <= tlen_nxt;
      hw_r   <= hw_nxt;
    end
  end

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    push && in_last_byte |=> cnt_r == '0 && tlen_r == '0 && hw_r == '0)
    else $error("frame state not cleared after last item");

  a_no_ihl_before_hdr: assert property (@(posedge clk) disable iff (!rst_n)
    push && !in_hdr |-> !push_entry.incl)
    else $error("ethernet header byte entered the crc");

  a_cnt_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    push && !in_last_byte |=> cnt_r >= $past(cnt_r))
    else $error("byte count went backwards within a frame");

endmodule

// File: hdl/ricrc_queue.sv
// ----------------------------------------------------------------------------
// ricrc_queue
// small fifo between the classifying front and the crc back end
// ----------------------------------------------------------------------------
module ricrc_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  ricrc_pkg::q_entry_t push_entry,
  input  logic                pop,
  output ricrc_pkg::q_entry_t head,
  output logic                empty,
  output logic                full
);
  import ricrc_pkg::*;

  q_entry_t          mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_r, wr_nxt;
  logic [QPTR_W-1:0] rd_r, rd_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    empty   = cnt_r == '0;
    full    = cnt_r == QCNT_W'(QDEPTH);
    head    = mem_r[rd_r];
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) wr_nxt = (wr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_r + QPTR_W'(1);
    if (pop)  rd_nxt = (rd_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_r + QPTR_W'(1);
    if (push && !pop) cnt_nxt = cnt_r + QCNT_W'(1);
    else if (pop && !push) cnt_nxt = cnt_r - QCNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> !pop)
    else $error("queue read while empty");

  a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0 || cnt_r == QCNT_W'(QDEPTH)) |-> wr_r == rd_r)
    else $error("queue pointers disagree with fill count");

endmodule

// File: hdl/ricrc_back.sv
// ----------------------------------------------------------------------------
// ricrc_back
// byte-wide crc-32 update and the registered result stage
// ----------------------------------------------------------------------------
module ricrc_back (
  input  logic                clk,
  input  logic                rst_n,
  input  ricrc_pkg::q_entry_t head,
  input  logic                empty,
  output logic                pop,
  input  logic                out_stall,
  output logic                out_valid,
  output logic [31:0]         out_icrc,
  output logic [2:0]          out_status
);
  import ricrc_pkg::*;

  logic [31:0] crc_r, crc_nxt;
  logic [31:0] crc_upd;
  logic        ov_r, ov_nxt;
  logic [31:0] icrc_r, icrc_nxt;
  status_t     st_r, st_nxt;
  logic        out_free;

  always_comb begin
    out_free = !ov_r || !out_stall;
    pop      = !empty && (!head.last || out_free);
    crc_upd  = head.incl ? crc_byte(crc_r, head.data) : crc_r;

    crc_nxt  = crc_r;
    ov_nxt   = ov_r && out_stall;
    icrc_nxt = icrc_r;
    st_nxt   = st_r;
    if (pop) begin
      if (head.last) begin
        crc_nxt  = CRC_PRESET;
        ov_nxt   = 1'b1;
        st_nxt   = head.status;
        icrc_nxt = (head.status == ST_OK) ? (crc_upd ^ CRC_ALL) : 32'h0;
      end else begin
        crc_nxt = crc_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= CRC_PRESET;
      ov_r  <= 1'b0;
    end else begin
      crc_r <= crc_nxt;
      ov_r  <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    icrc_r <= icrc_nxt;
    st_r   <= st_nxt;
  end

  assign out_valid  = ov_r;
  assign out_icrc   = icrc_r;
  assign out_status = st_r;

  a_err_zero_crc: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && st_r != ST_OK |-> icrc_r == 32'h0)
    else $error("nonzero crc reported with an error status");

  a_preset_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    pop && head.last |=> crc_r == CRC_PRESET)
    else $error("crc not reseeded after last item");

  a_no_result_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    pop && head.last |-> out_free)
    else $error("result overwritten before it was taken");

endmodule

// File: hdl/rocev2_icrc_engine.sv
// ----------------------------------------------------------------------------
// rocev2_icrc_engine
// streaming invariant crc over an ethernet / ipv4 / udp / bth frame
// ----------------------------------------------------------------------------
// usage
//   input channel: one frame byte per item on in_frame_byte, starting at the
//   ethernet destination address; in_last_byte marks the final byte. an item
//   is taken on a clock edge with in_valid high and in_stall low.
//   result channel: one item per frame (out_icrc, out_status) after its last
//   byte; taken on an edge with out_valid high and out_stall low.
// throughput
//   one byte per cycle sustained while in_stall stays low; the byte-wide crc
//   update in the back end sets this figure.
// result path
//   with the queue empty, the last byte is written into the queue on the edge
//   that takes it, then the crc and result registers load from the queue head
//   once the result stage is free; bytes already waiting in the queue go first.
// stall behavior
//   a stalled result holds; the back end keeps consuming non-final bytes, and
//   the four-entry queue absorbs the front until it fills, then in_stall rises.
// reset
//   synchronous, active low: frame counters clear, the crc reloads the value
//   after eight all-ones bytes, queue and result stage empty.
// ----------------------------------------------------------------------------
module rocev2_icrc_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_frame_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_icrc,
  output logic [2:0]  out_status
);
  import ricrc_pkg::*;

  logic     push;
  q_entry_t push_entry;
  logic     pop;
  q_entry_t head;
  logic     empty;
  logic     full;

  // queue full is the only back-pressure on the byte stream
  assign in_stall = full;

  ricrc_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_frame_byte (in_frame_byte),
    .in_last_byte  (in_last_byte),
    .push          (push),
    .push_entry    (push_entry)
  );

  ricrc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .empty      (empty),
    .full       (full)
  );

  ricrc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .empty      (empty),
    .pop        (pop),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .out_icrc   (out_icrc),
    .out_status (out_status)
  );

endmodule
